>>> hw/rtl/htc_pkg.sv
// Package with shared constants and codes of the heater thermostat controller.
`default_nettype none

package htc_pkg;

  // Sample averaging and converter width.
  localparam int AVG_DEPTH = 10;
  localparam int ADC_BITS  = 10;

  localparam int POS_W   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int TOTAL_W = ADC_BITS + ((AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 0);
  localparam int CMP_W   = TOTAL_W + 16;
  localparam int PROD_W  = ADC_BITS + 9;

  // Field widths.
  localparam int FUNC_W  = 2;
  localparam int TEMP_W  = 7;
  localparam int DISP_W  = 9;
  localparam int CADDR_W = 2;
  localparam int CDATA_W = 16;
  localparam int CHK_W   = 8;
  localparam int BLK_W   = 16;
  localparam int SET_W   = 16;

  // Temperature constants in degrees Celsius.
  localparam int TEMP_MAX     = 75;
  localparam int TEMP_MIN     = 35;
  localparam int TEMP_STEP    = 5;
  localparam int TEMP_DEFAULT = 60;
  localparam int BAND         = 5;
  localparam int SCALE_NUM    = 500;

  // Register reset values.
  localparam int CHECK_PERIOD_RST = 100;
  localparam int BLINK_PERIOD_RST = 500;
  localparam int SETTINGS_TO_RST  = 5000;

  // Event kinds.
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POWER  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PIN    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd3;

  // Register indexes.
  localparam logic [CADDR_W-1:0] REG_START_TEMP   = 2'd0;
  localparam logic [CADDR_W-1:0] REG_CHECK_PERIOD = 2'd1;
  localparam logic [CADDR_W-1:0] REG_BLINK_PERIOD = 2'd2;
  localparam logic [CADDR_W-1:0] REG_SETTINGS_TO  = 2'd3;

  typedef logic [TEMP_W-1:0] temp_t;

endpackage

`default_nettype wire

>>> hw/rtl/htc_in_if.sv
// Event input channel of the heater thermostat controller.
`default_nettype none

interface htc_in_if import htc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic                up_pin;
  logic                down_pin;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, func, up_pin, down_pin, adc_sample, input ready);
  modport sink   (input valid, func, up_pin, down_pin, adc_sample, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/htc_out_if.sv
// Status output channel of the heater thermostat controller.
`default_nettype none

interface htc_out_if import htc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              heater_drive;
  logic              fan_drive;
  logic              led_drive;
  logic              powered;
  logic              in_settings;
  temp_t             target_temp;
  logic [DISP_W-1:0] display_value;

  modport source (output valid, heater_drive, fan_drive, led_drive, powered, in_settings,
                  target_temp, display_value, input ready);
  modport sink   (input valid, heater_drive, fan_drive, led_drive, powered, in_settings,
                  target_temp, display_value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/htc_cfg_if.sv
// Register write channel of the heater thermostat controller.
`default_nettype none

interface htc_cfg_if import htc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CADDR_W-1:0] addr;
  logic [CDATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/heater_thermostat_controller_unit.sv
// Top level of the heater thermostat controller: event handling and status output.
//
// Usage. Events arrive on in_word as words: a tick, a power button press, a
// pin change of the up/down buttons, or a converter sample. Every accepted
// word yields exactly one status word on out_word, carrying heater, fan and
// LED drive levels, the power and settings flags, the set point and a display
// value. Registers are written through cfg_word, whose ready is always high;
// writes are expected only while no event is in flight.
// An accepted word is held in the input register; the update pass then
// writes the thermostat state and loads the output register.
// Throughput is one word per cycle while the receiver takes words, set by
// the single update pass that reads and writes the thermostat state together.
// When the receiver stalls, the output register holds its word and the input
// register can still take one more event; after that in_word.ready drops.
// Reset clears the control state, the sample ring and the counters, sets the
// set point to 60 and restores the register defaults.
`default_nettype none

module heater_thermostat_controller_unit import htc_pkg::*; (
  input  wire           clk,
  input  wire           rst_n,
  htc_in_if.sink        in_word,
  htc_out_if.source     out_word,
  htc_cfg_if.sink       cfg_word
);

  // Configuration registers.
  logic [CHK_W-1:0] check_period_r;
  logic [BLK_W-1:0] blink_period_r;
  logic [SET_W-1:0] settings_to_r;

  // Input register stage.
  logic                s1_valid_r;
  logic [FUNC_W-1:0]   s1_func_r;
  logic                s1_up_r;
  logic                s1_down_r;
  logic [ADC_BITS-1:0] s1_sample_r;

  // Thermostat state.
  logic                power_r, power_nxt;
  logic                settings_r, settings_nxt;
  temp_t               set_point_r, set_point_nxt;
  logic [CHK_W-1:0]    check_ticks_r, check_ticks_nxt;
  logic [BLK_W-1:0]    blink_ticks_r, blink_ticks_nxt;
  logic [SET_W-1:0]    settings_ticks_r, settings_ticks_nxt;
  logic                heater_r, heater_nxt;
  logic                fan_r, fan_nxt;
  logic                led_r, led_nxt;
  logic [ADC_BITS-1:0] ring_r [AVG_DEPTH];
  logic [POS_W-1:0]    ring_pos_r, ring_pos_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [ADC_BITS-1:0] latest_r, latest_nxt;

  // Output register.
  logic                out_valid_r;
  logic                out_heater_r;
  logic                out_fan_r;
  logic                out_led_r;
  logic                out_power_r;
  logic                out_settings_r;
  temp_t               out_target_r;
  logic [DISP_W-1:0]   out_display_r;

  logic                in_acc;
  logic                advance;
  logic                cfg_acc;

  // Threshold compare terms.
  logic [CMP_W-1:0]    lhs;
  logic [CMP_W-1:0]    lo_thr;
  logic [CMP_W-1:0]    hi_thr;
  logic [PROD_W-1:0]   disp_prod;

  // The stage advances when it holds a word and the output register is free or being drained.
  assign advance       = s1_valid_r && (!out_valid_r || out_word.ready);
  assign in_word.ready = !s1_valid_r || advance;
  assign in_acc        = in_word.valid && in_word.ready;
  assign cfg_word.ready = 1'b1;
  assign cfg_acc       = cfg_word.valid;

  // Exact band test: total*500 against (set point -/+ 5) * depth * 2^ADC_BITS.
  assign lhs    = CMP_W'(total_r) * CMP_W'(SCALE_NUM);
  assign lo_thr = (CMP_W'(set_point_r - temp_t'(BAND)) * CMP_W'(AVG_DEPTH)) << ADC_BITS;
  assign hi_thr = (CMP_W'(set_point_r + temp_t'(BAND)) * CMP_W'(AVG_DEPTH)) << ADC_BITS;

  always_comb begin
    power_nxt          = power_r;
    settings_nxt       = settings_r;
    set_point_nxt      = set_point_r;
    check_ticks_nxt    = check_ticks_r;
    blink_ticks_nxt    = blink_ticks_r;
    settings_ticks_nxt = settings_ticks_r;
    heater_nxt         = heater_r;
    fan_nxt            = fan_r;
    led_nxt            = led_r;
    ring_pos_nxt       = ring_pos_r;
    total_nxt          = total_r;
    latest_nxt         = latest_r;

    case (s1_func_r)
      FUNC_TICK: begin
        // Counters saturate instead of wrapping.
        if (check_ticks_r != '1) begin
          check_ticks_nxt = check_ticks_r + CHK_W'(1);
        end
        if (blink_ticks_r != '1) begin
          blink_ticks_nxt = blink_ticks_r + BLK_W'(1);
        end
        if (settings_ticks_r != '1) begin
          settings_ticks_nxt = settings_ticks_r + SET_W'(1);
        end
        if (power_r) begin
          if (settings_ticks_nxt > settings_to_r) begin
            settings_nxt = 1'b0;
          end
          if (check_ticks_nxt >= check_period_r) begin
            // Hysteresis: heat at or below the low edge, cool at or above the high edge.
            if (lhs <= lo_thr) begin
              heater_nxt = 1'b1;
              fan_nxt    = 1'b0;
            end else if (lhs >= hi_thr) begin
              heater_nxt = 1'b0;
              fan_nxt    = 1'b1;
            end
            if (heater_nxt) begin
              if (blink_ticks_nxt >= blink_period_r) begin
                led_nxt         = !led_r;
                blink_ticks_nxt = '0;
              end
            end else begin
              led_nxt = 1'b1;
            end
            check_ticks_nxt = '0;
          end
        end
      end
      FUNC_POWER: begin
        power_nxt    = !power_r;
        settings_nxt = 1'b0;
      end
      FUNC_PIN: begin
        if (power_r) begin
          if (settings_r) begin
            if (s1_up_r && (set_point_r <= temp_t'(TEMP_MAX - TEMP_STEP))) begin
              set_point_nxt = set_point_r + temp_t'(TEMP_STEP);
            end else if (s1_down_r && (set_point_r >= temp_t'(TEMP_MIN + TEMP_STEP))) begin
              set_point_nxt = set_point_r - temp_t'(TEMP_STEP);
            end
          end
          settings_nxt       = 1'b1;
          settings_ticks_nxt = '0;
        end
      end
      default: begin
        // Temperature sample: replace the oldest ring entry and keep the running total.
        total_nxt    = total_r - TOTAL_W'(ring_r[ring_pos_r]) + TOTAL_W'(s1_sample_r);
        ring_pos_nxt = (ring_pos_r == POS_W'(AVG_DEPTH - 1)) ? '0 : ring_pos_r + POS_W'(1);
        latest_nxt   = s1_sample_r;
      end
    endcase

    // Heater and fan stay off while the unit is powered down.
    if (!power_nxt) begin
      heater_nxt = 1'b0;
      fan_nxt    = 1'b0;
    end
  end

  assign disp_prod = PROD_W'(latest_nxt) * PROD_W'(SCALE_NUM);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
    if (in_acc) begin
      s1_func_r   <= in_word.func;
      s1_up_r     <= in_word.up_pin;
      s1_down_r   <= in_word.down_pin;
      s1_sample_r <= in_word.adc_sample;
    end
  end

  // Configuration registers and thermostat state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_period_r   <= CHK_W'(CHECK_PERIOD_RST);
      blink_period_r   <= BLK_W'(BLINK_PERIOD_RST);
      settings_to_r    <= SET_W'(SETTINGS_TO_RST);
      power_r          <= 1'b0;
      settings_r       <= 1'b0;
      set_point_r      <= temp_t'(TEMP_DEFAULT);
      check_ticks_r    <= '0;
      blink_ticks_r    <= '0;
      settings_ticks_r <= '0;
      heater_r         <= 1'b0;
      fan_r            <= 1'b0;
      led_r            <= 1'b0;
      ring_pos_r       <= '0;
      total_r          <= '0;
      latest_r         <= '0;
      for (int i = 0; i < AVG_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
    end else if (cfg_acc) begin
      case (cfg_word.addr)
        REG_START_TEMP: begin
          if (cfg_word.data[7:0] inside {[TEMP_MIN:TEMP_MAX]}) begin
            set_point_r <= cfg_word.data[TEMP_W-1:0];
          end else begin
            set_point_r <= temp_t'(TEMP_DEFAULT);
          end
        end
        REG_CHECK_PERIOD: check_period_r <= cfg_word.data[CHK_W-1:0];
        REG_BLINK_PERIOD: blink_period_r <= cfg_word.data[BLK_W-1:0];
        REG_SETTINGS_TO:  settings_to_r  <= cfg_word.data[SET_W-1:0];
        default: begin
        end
      endcase
    end else if (advance) begin
      power_r          <= power_nxt;
      settings_r       <= settings_nxt;
      set_point_r      <= set_point_nxt;
      check_ticks_r    <= check_ticks_nxt;
      blink_ticks_r    <= blink_ticks_nxt;
      settings_ticks_r <= settings_ticks_nxt;
      heater_r         <= heater_nxt;
      fan_r            <= fan_nxt;
      led_r            <= led_nxt;
      ring_pos_r       <= ring_pos_nxt;
      total_r          <= total_nxt;
      latest_r         <= latest_nxt;
      if (s1_func_r == FUNC_SAMPLE) begin
        ring_r[ring_pos_r] <= s1_sample_r;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_heater_r   <= heater_nxt;
      out_fan_r      <= fan_nxt;
      out_led_r      <= led_nxt;
      out_power_r    <= power_nxt;
      out_settings_r <= settings_nxt;
      out_target_r   <= set_point_nxt;
      if (settings_nxt) begin
        out_display_r <= DISP_W'(set_point_nxt);
      end else begin
        out_display_r <= DISP_W'(disp_prod >> ADC_BITS);
      end
    end
  end

  assign out_word.valid         = out_valid_r;
  assign out_word.heater_drive  = out_heater_r;
  assign out_word.fan_drive     = out_fan_r;
  assign out_word.led_drive     = out_led_r;
  assign out_word.powered       = out_power_r;
  assign out_word.in_settings   = out_settings_r;
  assign out_word.target_temp   = out_target_r;
  assign out_word.display_value = out_display_r;

endmodule

`default_nettype wire

>>> test/tb_heater_thermostat_controller_unit.sv
// Self-checking testbench of the heater thermostat controller unit.
`timescale 1ns / 100ps

module tb_heater_thermostat_controller_unit;
  import htc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DIR_ROWS    = 22;
  localparam int NUM_PLANS   = 10;
  localparam int SAT_PLAN    = 9;
  localparam int PHASE_ITEMS = 120;
  localparam int SAT_TICKS   = 300;

  // One event word as the testbench sees it.
  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic                up_pin;
    logic                down_pin;
    logic [ADC_BITS-1:0] adc_sample;
  } event_word_t;

  // One status word, field for field as on the output channel.
  typedef struct packed {
    logic              heater_drive;
    logic              fan_drive;
    logic              led_drive;
    logic              powered;
    logic              in_settings;
    temp_t             target_temp;
    logic [DISP_W-1:0] display_value;
  } status_word_t;

  // A row of the directed table. When typed is set, want is the status word
  // that this row must give, written down by hand.
  typedef struct {
    event_word_t  ev;
    bit           typed;
    status_word_t want;
  } dir_row_t;

  // Register settings and idling of one phase. A negative register value
  // means a small random value picked when the phase starts.
  typedef struct {
    int start_val;
    int chk;
    int blk;
    int sto;
    int src;
    int snk;
  } phase_plan_t;

  logic clk;
  logic rst_n;

  htc_in_if  in_bus ();
  htc_out_if out_bus ();
  htc_cfg_if cfg_bus ();

  heater_thermostat_controller_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_bus),
    .out_word (out_bus),
    .cfg_word (cfg_bus)
  );

  // Expected status words, oldest first.
  status_word_t status_queue[$];

  int fail_count    = 0;
  int cycle_count   = 0;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;

  // Simulated water temperature in degrees. It rises while the predicted
  // heater is on and falls while the fan runs, so that the random samples
  // drive the thermostat through both switching thresholds.
  int water_deg = 50;

  // Thermostat state as the testbench predicts it.
  logic                th_power;
  logic                th_settings;
  temp_t               th_set_point;
  logic [CHK_W-1:0]    th_chk_ticks;
  logic [BLK_W-1:0]    th_blk_ticks;
  logic [SET_W-1:0]    th_set_ticks;
  logic                th_heater;
  logic                th_fan;
  logic                th_led;
  logic [ADC_BITS-1:0] th_ring [AVG_DEPTH];
  logic [POS_W-1:0]    th_ring_pos;
  logic [TOTAL_W-1:0]  th_total;
  logic [ADC_BITS-1:0] th_latest;

  // Register copies.
  logic [CHK_W-1:0]    th_chk_period;
  logic [BLK_W-1:0]    th_blk_period;
  logic [SET_W-1:0]    th_set_timeout;

  dir_row_t    steps [DIR_ROWS];
  phase_plan_t plan [NUM_PLANS];

  // The clock runs from time zero with a period of 8 ns.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver stalls at random; the stall rate is set per phase. Ready
  // changes at the falling edge so that it is stable at the rising edge.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // The watchdog ends a run that hangs. It is a plain cycle counter.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic event_word_t make_event(input logic [FUNC_W-1:0] func, input bit up,
                                             input bit down, input int adc);
    event_word_t w;
    w.func       = func;
    w.up_pin     = up;
    w.down_pin   = down;
    w.adc_sample = ADC_BITS'(adc);
    return w;
  endfunction

  function automatic status_word_t make_status(input bit heat, input bit fan, input bit led,
                                               input bit pwr, input bit sett, input int target,
                                               input int disp);
    status_word_t s;
    s.heater_drive  = heat;
    s.fan_drive     = fan;
    s.led_drive     = led;
    s.powered       = pwr;
    s.in_settings   = sett;
    s.target_temp   = temp_t'(target);
    s.display_value = DISP_W'(disp);
    return s;
  endfunction

  // Advances the predicted thermostat by one event and returns the status
  // word that the event must give.
  function automatic status_word_t predict_status(input event_word_t w);
    status_word_t s;
    logic [POS_W-1:0] p;
    longint avg_scaled;
    longint unit;
    case (w.func)
      FUNC_TICK: begin
        // All three counters saturate instead of wrapping.
        if (th_chk_ticks != '1) th_chk_ticks++;
        if (th_blk_ticks != '1) th_blk_ticks++;
        if (th_set_ticks != '1) th_set_ticks++;
        if (th_power) begin
          if (th_set_ticks > th_set_timeout) th_settings = 1'b0;
          // A check period of zero compares on every tick.
          if (th_chk_ticks >= th_chk_period) begin
            // The average of the ring against the set point, scaled so
            // that both sides are exact integers.
            avg_scaled = longint'(th_total) * SCALE_NUM;
            unit = (longint'(1) << ADC_BITS) * AVG_DEPTH;
            if (th_set_point >= BAND &&
                avg_scaled <= (longint'(th_set_point) - BAND) * unit) begin
              th_heater = 1'b1;
              th_fan    = 1'b0;
            end else if (avg_scaled >= (longint'(th_set_point) + BAND) * unit) begin
              th_heater = 1'b0;
              th_fan    = 1'b1;
            end
            // The LED blinks while heating and stays lit otherwise.
            if (th_heater) begin
              if (th_blk_ticks >= th_blk_period) begin
                th_led       = ~th_led;
                th_blk_ticks = '0;
              end
            end else begin
              th_led = 1'b1;
            end
            th_chk_ticks = '0;
          end
        end
      end
      FUNC_POWER: begin
        th_power    = ~th_power;
        th_settings = 1'b0;
      end
      FUNC_PIN: begin
        // Pin changes only count while powered; the first one opens the
        // settings, later ones step the set point with up taking priority.
        if (th_power) begin
          if (th_settings) begin
            if (w.up_pin && int'(th_set_point) + TEMP_STEP <= TEMP_MAX)
              th_set_point = th_set_point + temp_t'(TEMP_STEP);
            else if (w.down_pin && int'(th_set_point) >= TEMP_MIN + TEMP_STEP)
              th_set_point = th_set_point - temp_t'(TEMP_STEP);
          end
          th_settings  = 1'b1;
          th_set_ticks = '0;
        end
      end
      default: begin
        // Empty ring entries are zero, so a partly filled ring simply
        // pulls the average down.
        p = (int'(th_ring_pos) < AVG_DEPTH) ? th_ring_pos : '0;
        th_total    = th_total - TOTAL_W'(th_ring[p]);
        th_total    = th_total + TOTAL_W'(w.adc_sample);
        th_ring[p]  = w.adc_sample;
        th_ring_pos = (int'(p) + 1 < AVG_DEPTH) ? p + POS_W'(1) : '0;
        th_latest   = w.adc_sample;
      end
    endcase
    if (!th_power) begin
      th_heater = 1'b0;
      th_fan    = 1'b0;
    end
    s.heater_drive = th_heater;
    s.fan_drive    = th_fan;
    s.led_drive    = th_led;
    s.powered      = th_power;
    s.in_settings  = th_settings;
    s.target_temp  = th_set_point;
    if (th_settings)
      s.display_value = DISP_W'(th_set_point);
    else
      s.display_value = DISP_W'((int'(th_latest) * SCALE_NUM) >> ADC_BITS);
    return s;
  endfunction

  // Sends one event word. The sender may idle first; the word is held until
  // it is accepted, and the expected status word is queued at that edge.
  // The task starts and ends at a falling edge.
  task automatic send_word(input event_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.func       <= w.func;
    in_bus.up_pin     <= w.up_pin;
    in_bus.down_pin   <= w.down_pin;
    in_bus.adc_sample <= w.adc_sample;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    status_queue.push_back(predict_status(w));
    @(negedge clk);
  endtask

  // The sender goes quiet until every expected status word has come back.
  // The task always waits for a falling edge, so valid is never lowered and
  // raised in the same step.
  task automatic drain(input int settle);
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (status_queue.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // Writes one register and mirrors the write in the predicted state. Valid
  // stays high for the next write; the caller lowers it.
  task automatic cfg_write(input logic [CADDR_W-1:0] idx, input logic [CDATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_START_TEMP: begin
        // Set points outside the allowed range fall back to the default.
        if (data[7:0] >= TEMP_MIN && data[7:0] <= TEMP_MAX)
          th_set_point = temp_t'(data[7:0]);
        else
          th_set_point = temp_t'(TEMP_DEFAULT);
      end
      REG_CHECK_PERIOD: th_chk_period  = data[CHK_W-1:0];
      REG_BLINK_PERIOD: th_blk_period  = data[BLK_W-1:0];
      default:          th_set_timeout = data[SET_W-1:0];
    endcase
    @(negedge clk);
  endtask

  function automatic int pick_value(input int v, input int hi);
    return (v < 0) ? int'($urandom_range(hi, 1)) : v;
  endfunction

  // Writes all four registers for a phase and sets its idling. Start temperature
  // and check period get random upper data bits, which the block must drop.
  task automatic configure(input phase_plan_t pp);
    logic [7:0] junk_a;
    logic [7:0] junk_b;
    junk_a = 8'($urandom_range(255));
    junk_b = 8'($urandom_range(255));
    cfg_write(REG_START_TEMP, {junk_a, 8'(pp.start_val)});
    cfg_write(REG_CHECK_PERIOD, {junk_b, 8'(pick_value(pp.chk, 10))});
    cfg_write(REG_BLINK_PERIOD, 16'(pick_value(pp.blk, 10)));
    cfg_write(REG_SETTINGS_TO, 16'(pick_value(pp.sto, 40)));
    cfg_bus.valid <= 1'b0;
    src_idle_pct  = pp.src;
    snk_stall_pct = pp.snk;
  endtask

  // One random event word. Mostly a powered-on mix of ticks, samples near
  // the water temperature and button changes; the rest is noise such as
  // power toggles, buttons while off and samples anywhere in range. The
  // fields that an event kind ignores carry random values.
  task automatic send_random();
    event_word_t w;
    int pick;
    int code;
    w.func       = FUNC_TICK;
    w.up_pin     = 1'($urandom_range(1));
    w.down_pin   = 1'($urandom_range(1));
    w.adc_sample = ADC_BITS'($urandom_range(1023));
    pick = $urandom_range(99);
    if (!th_power && pick < 85) begin
      w.func = FUNC_POWER;
    end else if (pick < 40) begin
      w.func = FUNC_TICK;
    end else if (pick < 72) begin
      w.func = FUNC_SAMPLE;
      if ($urandom_range(3) != 0) begin
        code = (water_deg << ADC_BITS) / SCALE_NUM + int'($urandom_range(6)) - 3;
        w.adc_sample = (code < 0) ? '0 : ADC_BITS'(code);
      end
    end else if (pick < 94) begin
      w.func = FUNC_PIN;
    end else if (pick < 97) begin
      w.func = FUNC_POWER;
    end else begin
      w.func = FUNC_W'($urandom_range(3));
    end
    send_word(w);
    if (w.func == FUNC_SAMPLE) begin
      if (th_heater)
        water_deg = water_deg + int'($urandom_range(2));
      else if (th_fan)
        water_deg = water_deg - int'($urandom_range(2));
      else
        water_deg = water_deg + int'($urandom_range(2)) - 1;
      if (water_deg < 15) water_deg = 15;
      if (water_deg > 99) water_deg = 99;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Every accepted status word is compared field by field with the oldest
  // expectation. A word with nothing expected is a failure by itself.
  always @(posedge clk) begin : status_monitor
    status_word_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (status_queue.size() == 0) begin
        $display("%0t: unexpected status word, expected none, actual heater %0d fan %0d",
                 $time, out_bus.heater_drive, out_bus.fan_drive);
        fail_count++;
      end else begin
        want = status_queue.pop_front();
        check_field("heater_drive", want.heater_drive, out_bus.heater_drive);
        check_field("fan_drive", want.fan_drive, out_bus.fan_drive);
        check_field("led_drive", want.led_drive, out_bus.led_drive);
        check_field("powered", want.powered, out_bus.powered);
        check_field("in_settings", want.in_settings, out_bus.in_settings);
        check_field("target_temp", want.target_temp, out_bus.target_temp);
        check_field("display_value", want.display_value, out_bus.display_value);
      end
    end
  end

  initial begin : stimulus
    // All block inputs are known from time zero.
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.func        = FUNC_TICK;
    in_bus.up_pin      = 1'b0;
    in_bus.down_pin    = 1'b0;
    in_bus.adc_sample  = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.addr       = REG_START_TEMP;
    cfg_bus.data       = '0;

    // Predicted state and registers after reset.
    th_power       = 1'b0;
    th_settings    = 1'b0;
    th_set_point   = temp_t'(TEMP_DEFAULT);
    th_chk_ticks   = '0;
    th_blk_ticks   = '0;
    th_set_ticks   = '0;
    th_heater      = 1'b0;
    th_fan         = 1'b0;
    th_led         = 1'b0;
    th_ring_pos    = '0;
    th_total       = '0;
    th_latest      = '0;
    th_chk_period  = CHK_W'(CHECK_PERIOD_RST);
    th_blk_period  = BLK_W'(BLINK_PERIOD_RST);
    th_set_timeout = SET_W'(SETTINGS_TO_RST);
    for (int k = 0; k < AVG_DEPTH; k++) th_ring[k] = '0;

    // Phase plans. The first one sets up the directed table: a set point
    // at the top of the range, checks and blinks on every tick, and a
    // settings timeout short enough to run out within a few ticks. The
    // last one runs the check counter into saturation.
    plan[0] = '{75, 1, 1, 3, 0, 0};
    plan[1] = '{60, 1, 1, 1, 0, 0};
    plan[2] = '{35, 2, 3, 20, 57, 0};
    plan[3] = '{75, 0, 0, 0, 0, 57};
    plan[4] = '{255, 5, 65535, 65535, 16, 16};
    plan[5] = '{0, 255, 2, 8, 57, 0};
    plan[6] = '{34, -1, -1, -1, 0, 57};
    plan[7] = '{40, -1, -1, -1, 16, 16};
    plan[8] = '{76, 3, 7, 30, 0, 0};
    plan[9] = '{50, 255, 65535, 65535, 0, 0};

    // Directed table. Row 0 runs with the reset registers; the others run
    // with the first plan.
    steps[0]  = '{make_event(FUNC_TICK, 0, 0, 0), 1'b1, make_status(0, 0, 0, 0, 0, 60, 0)};
    // Full-scale sample while off, with the button bits set and ignored.
    steps[1]  = '{make_event(FUNC_SAMPLE, 1, 1, 1023), 1'b1,
                  make_status(0, 0, 0, 0, 0, 75, 499)};
    // A button change while off is ignored.
    steps[2]  = '{make_event(FUNC_PIN, 1, 0, 0), 1'b1, make_status(0, 0, 0, 0, 0, 75, 499)};
    steps[3]  = '{make_event(FUNC_POWER, 0, 0, 0), 1'b0, '0};
    // The first change opens the settings without stepping.
    steps[4]  = '{make_event(FUNC_PIN, 1, 1, 0), 1'b0, '0};
    // Up at the top of the range stays put.
    steps[5]  = '{make_event(FUNC_PIN, 1, 0, 0), 1'b0, '0};
    steps[6]  = '{make_event(FUNC_PIN, 0, 1, 0), 1'b0, '0};
    // Both buttons: up wins.
    steps[7]  = '{make_event(FUNC_PIN, 1, 1, 0), 1'b0, '0};
    // A single sample in an otherwise empty ring reads as cold: the heater
    // comes on, the LED blinks, and the settings run out on the fourth tick.
    steps[8]  = '{make_event(FUNC_TICK, 0, 0, 0), 1'b0, '0};
    steps[9]  = '{make_event(FUNC_TICK, 1, 0, 1023), 1'b0, '0};
    steps[10] = '{make_event(FUNC_TICK, 0, 1, 0), 1'b0, '0};
    steps[11] = '{make_event(FUNC_TICK, 1, 1, 1023), 1'b0, '0};
    // Two full-scale samples are above the upper threshold: fan on.
    steps[12] = '{make_event(FUNC_SAMPLE, 0, 0, 1023), 1'b0, '0};
    steps[13] = '{make_event(FUNC_TICK, 0, 0, 0), 1'b0, '0};
    steps[14] = '{make_event(FUNC_SAMPLE, 1, 1, 0), 1'b0, '0};
    // Power off forces heater and fan off and leaves the LED as it was.
    steps[15] = '{make_event(FUNC_POWER, 0, 0, 0), 1'b1, make_status(0, 0, 1, 0, 0, 75, 0)};
    steps[16] = '{make_event(FUNC_TICK, 0, 0, 0), 1'b0, '0};
    steps[17] = '{make_event(FUNC_PIN, 0, 1, 0), 1'b0, '0};
    steps[18] = '{make_event(FUNC_POWER, 0, 0, 0), 1'b0, '0};
    // Changes with neither button held open and keep the settings.
    steps[19] = '{make_event(FUNC_PIN, 0, 0, 0), 1'b0, '0};
    steps[20] = '{make_event(FUNC_PIN, 0, 0, 0), 1'b0, '0};
    steps[21] = '{make_event(FUNC_TICK, 0, 0, 0), 1'b0, '0};

    // Synchronous reset from time zero, released at a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Typed rows replace the predicted expectation with the
    // hand-written one.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == 1) begin
        drain(3);
        configure(plan[0]);
      end
      send_word(steps[i].ev);
      if (steps[i].typed) status_queue[$] = steps[i].want;
    end

    // Random phases, each with its own registers and idling. Registers
    // change only once the block has gone quiet.
    for (int ph = 1; ph < SAT_PLAN; ph++) begin
      drain(3);
      configure(plan[ph]);
      water_deg = int'(th_set_point);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Now and then the sender waits for every status word to return;
        // the first phase does so once for certain.
        if ((ph == 1 && n == PHASE_ITEMS / 2) || $urandom_range(199) == 0)
          drain(0);
        send_random();
      end
    end

    // Saturation phase: with power off nothing clears the counters, so a
    // run of ticks drives the check counter to its maximum. Random traffic
    // then powers the block on and works from the saturated counter.
    drain(3);
    configure(plan[SAT_PLAN]);
    if (th_power) send_word(make_event(FUNC_POWER, 0, 0, 0));
    repeat (SAT_TICKS)
      send_word(make_event(FUNC_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                           int'($urandom_range(1023))));
    repeat (40) send_random();

    // Wait for the last status words, then keep watching for any extra word
    // from the block.
    drain(0);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/htc_pkg.sv
hw/rtl/htc_in_if.sv
hw/rtl/htc_out_if.sv
hw/rtl/htc_cfg_if.sv
hw/rtl/heater_thermostat_controller_unit.sv
test/tb_heater_thermostat_controller_unit.sv
